[rtl/spm_pkg.sv]
`default_nettype none

package spm_pkg;

	localparam int PAT_MAX    = 16;
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CNT_W      = $clog2(PAT_MAX + 1);
	localparam int IDX_W      = $clog2(PAT_MAX);

	localparam logic [BYTE_W-1:0] NEWLINE  = 8'd10;
	localparam logic [BYTE_W-1:0] ASTERISK = 8'd42;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [PAT_MAX-1:0][BYTE_W-1:0] pat_bytes_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LEN  = 2'd0,
		REG_PATTERN_LOW  = 2'd1,
		REG_PATTERN_HIGH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_input;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/stream_pattern_masker.sv]
// Channel   Direction  Handshake              Payload
// byte      in         byte_valid/byte_stall  byte_item (data_byte, end_of_input)
// res       out        res_valid/res_stall    res_item (out_byte, last)
// cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_wdata
//
// An item with n results holds the byte channel until its last result is out;
// the cell row shifts one held byte per cycle into the single result port; a
// byte with zero or one result is taken every cycle. Both need buffer room.
// Reset clears the fill count, drain counters, line flag, registers and the
// output buffer at once; there is no clearing pass.
// A two-entry output buffer lets a byte be taken while one result waits;
// byte_stall rises only while a drain is owed or the buffer is full.
`default_nettype none

module stream_pattern_masker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 byte_valid,
	output logic                                      byte_stall,
	input  wire spm_pkg::in_item_t                    byte_item,
	output logic                                      res_valid,
	input  wire logic                                 res_stall,
	output spm_pkg::out_item_t                        res_item,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [spm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [spm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

	// configuration registers
	logic [spm_pkg::LEN_W-1:0]      pattern_len_q;
	logic [spm_pkg::CFG_DATA_W-1:0] pattern_low_q;
	logic [spm_pkg::CFG_DATA_W-1:0] pattern_high_q;

	// window control: held byte count, results still owed, line flag
	logic [spm_pkg::CNT_W-1:0] fill_q;
	logic [spm_pkg::CNT_W-1:0] plain_q;
	logic [spm_pkg::CNT_W-1:0] ast_q;
	logic                      line_nonempty_q;

	spm_pkg::pat_bytes_t       pat;
	logic [spm_pkg::CNT_W-1:0] len_eff;

	spm_pkg::cell_ctrl_t       cell_ctrl [spm_pkg::PAT_MAX];
	spm_pkg::byte_t            cell_byte [spm_pkg::PAT_MAX];
	logic [spm_pkg::PAT_MAX-1:0] cell_hits [spm_pkg::PAT_MAX];
	spm_pkg::byte_t            load_byte;

	logic                      accept;
	logic                      busy;
	logic                      fifo_full;
	logic                      is_eoi;
	logic                      is_nl;
	logic                      is_data;
	logic                      append;

	logic [spm_pkg::PAT_MAX-1:0] start_ok;
	logic [spm_pkg::CNT_W-1:0] sel_start;
	logic [spm_pkg::CNT_W-1:0] tail_len;
	logic                      found;

	logic [spm_pkg::CNT_W-1:0] plain_new;
	logic [spm_pkg::CNT_W-1:0] ast_new;
	logic [spm_pkg::CNT_W-1:0] cur_plain;
	logic [spm_pkg::CNT_W-1:0] cur_ast;
	logic [spm_pkg::CNT_W-1:0] cur_fill;
	logic                      emit;
	spm_pkg::out_item_t        emit_item;

	assign cfg_ready = 1'b1;

	// byte 0 of the pattern sits in the low bits of pattern_low
	assign pat = spm_pkg::pat_bytes_t'({pattern_high_q, pattern_low_q});

	// saturate the length to the cell count
	assign len_eff = (spm_pkg::CNT_W'(pattern_len_q) > spm_pkg::CNT_W'(spm_pkg::PAT_MAX))
		? spm_pkg::CNT_W'(spm_pkg::PAT_MAX) : spm_pkg::CNT_W'(pattern_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_len_q  <= '0;
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spm_pkg::REG_PATTERN_LEN:  pattern_len_q  <= cfg_wdata[spm_pkg::LEN_W-1:0];
				spm_pkg::REG_PATTERN_LOW:  pattern_low_q  <= cfg_wdata;
				spm_pkg::REG_PATTERN_HIGH: pattern_high_q <= cfg_wdata;
				default: begin
					// no register at this index: drop the write
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Item decode. A newline, or end of input on a line with content, puts a
	// newline byte into the row behind the held bytes so that the drain gives
	// it out last and unmasked.
	// ---------------------------------------------------------------------
	assign busy       = (plain_q != '0) || (ast_q != '0);
	assign byte_stall = busy || fifo_full;
	assign accept     = byte_valid && !byte_stall;

	assign is_eoi  = byte_item.end_of_input;
	assign is_nl   = !is_eoi && (byte_item.data_byte == spm_pkg::NEWLINE);
	assign is_data = !is_eoi && !is_nl;
	assign append  = accept && (is_data || is_nl || (is_eoi && line_nonempty_q));

	assign load_byte = is_data ? byte_item.data_byte : spm_pkg::NEWLINE;

	// ---------------------------------------------------------------------
	// Window match. With the new byte loaded at place fill_q, a start s is
	// good when the bytes from s on form a prefix of the pattern no longer
	// than the pattern. Take the leftmost good start; everything in front of
	// it can no longer begin a match and goes out unchanged.
	// ---------------------------------------------------------------------
	always_comb begin
		for (int s = 0; s < spm_pkg::PAT_MAX; s++) begin
			start_ok[s] = (spm_pkg::CNT_W'(s) <= fill_q) &&
				(spm_pkg::CNT_W'(int'(fill_q) + 1 - s) <= len_eff);
			for (int i = 0; i < spm_pkg::PAT_MAX; i++) begin
				if (i >= s && spm_pkg::CNT_W'(i) <= fill_q) begin
					start_ok[s] = start_ok[s] && cell_hits[i][spm_pkg::IDX_W'(i - s)];
				end
			end
		end
	end

	always_comb begin
		sel_start = fill_q + spm_pkg::CNT_W'(1);
		for (int s = spm_pkg::PAT_MAX - 1; s >= 0; s--) begin
			if (start_ok[s]) begin
				sel_start = spm_pkg::CNT_W'(s);
			end
		end
	end

	assign tail_len = fill_q + spm_pkg::CNT_W'(1) - sel_start;
	assign found    = (len_eff != '0) && (tail_len == len_eff);

	always_comb begin
		priority if (is_data) begin
			plain_new = sel_start;
			ast_new   = found ? tail_len : '0;
		end else if (append) begin
			plain_new = fill_q + spm_pkg::CNT_W'(1);
			ast_new   = '0;
		end else begin
			plain_new = '0;
			ast_new   = '0;
		end
	end

	// ---------------------------------------------------------------------
	// Drain: plain bytes first, then asterisks for a found match. Each result
	// shifts the row by one place. The first result of an item leaves in the
	// cycle the item is taken.
	// ---------------------------------------------------------------------
	assign cur_plain = accept ? plain_new : plain_q;
	assign cur_ast   = accept ? ast_new : ast_q;
	always_comb begin
		priority if (!accept) begin
			cur_fill = fill_q;
		end else if (append) begin
			cur_fill = fill_q + spm_pkg::CNT_W'(1);
		end else begin
			cur_fill = '0;
		end
	end

	assign emit = ((cur_plain != '0) || (cur_ast != '0)) && !fifo_full;

	assign emit_item.out_byte = (cur_plain != '0) ? cell_byte[0] : spm_pkg::ASTERISK;
	assign emit_item.last     = ((cur_plain + cur_ast) == spm_pkg::CNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q          <= '0;
			plain_q         <= '0;
			ast_q           <= '0;
			line_nonempty_q <= 1'b0;
		end else begin
			if (emit) begin
				fill_q <= cur_fill - spm_pkg::CNT_W'(1);
				if (cur_plain != '0) begin
					plain_q <= cur_plain - spm_pkg::CNT_W'(1);
					ast_q   <= cur_ast;
				end else begin
					plain_q <= cur_plain;
					ast_q   <= cur_ast - spm_pkg::CNT_W'(1);
				end
			end else begin
				fill_q  <= cur_fill;
				plain_q <= cur_plain;
				ast_q   <= cur_ast;
			end
			if (accept) begin
				line_nonempty_q <= is_data;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Row of cells: cell k holds window place k and hands its byte to cell
	// k-1 on every result given out.
	// ---------------------------------------------------------------------
	for (genvar k = 0; k < spm_pkg::PAT_MAX; k++) begin : g_cell
		assign cell_ctrl[k].load  = append && (fill_q[spm_pkg::IDX_W-1:0] == spm_pkg::IDX_W'(k));
		assign cell_ctrl[k].shift = emit;

		if (k == spm_pkg::PAT_MAX - 1) begin : g_end
			spm_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[k]),
				.new_byte  (load_byte),
				.next_byte (spm_pkg::byte_t'(0)),
				.pattern   (pat),
				.cur_byte  (cell_byte[k]),
				.hits      (cell_hits[k])
			);
		end else begin : g_mid
			spm_cell u_cell (
				.clk       (clk),
				.ctrl      (cell_ctrl[k]),
				.new_byte  (load_byte),
				.next_byte (cell_byte[k+1]),
				.pattern   (pat),
				.cur_byte  (cell_byte[k]),
				.hits      (cell_hits[k])
			);
		end
	end

	spm_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit),
		.push_item (emit_item),
		.full      (fifo_full),
		.valid     (res_valid),
		.stall     (res_stall),
		.item      (res_item)
	);

endmodule

`default_nettype wire

[rtl/spm_cell.sv]
`default_nettype none

module spm_cell (
	input  wire logic                clk,
	input  wire spm_pkg::cell_ctrl_t ctrl,
	input  wire spm_pkg::byte_t      new_byte,
	input  wire spm_pkg::byte_t      next_byte,
	input  wire spm_pkg::pat_bytes_t pattern,
	output spm_pkg::byte_t           cur_byte,
	output logic [spm_pkg::PAT_MAX-1:0] hits
);

	spm_pkg::byte_t byte_q;

	// the byte this cell shows this cycle, with a fresh load already folded in
	assign cur_byte = ctrl.load ? new_byte : byte_q;

	always_comb begin
		for (int j = 0; j < spm_pkg::PAT_MAX; j++) begin
			hits[j] = (cur_byte == pattern[j]);
		end
	end

	// shift wins: a byte loaded into this place moves on to the left neighbour
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= next_byte;
		end else if (ctrl.load) begin
			byte_q <= new_byte;
		end
	end

endmodule

`default_nettype wire

[rtl/spm_out_fifo.sv]
`default_nettype none

module spm_out_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire spm_pkg::out_item_t push_item,
	output logic                    full,
	output logic                    valid,
	input  wire logic               stall,
	output spm_pkg::out_item_t      item
);

	spm_pkg::out_item_t entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               pop;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign item  = entry_q[rd_ptr_q];
	assign pop   = valid && !stall;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

[rtl/spm_checker.sv]
`default_nettype none

module spm_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	input  wire logic               res_stall,
	input  wire spm_pkg::out_item_t res_item,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// a newline always closes the transaction's results
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.out_byte == spm_pkg::NEWLINE) |-> res_item.last)
		else $error("newline result without last");

	// register writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

	// no result shows while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind stream_pattern_masker spm_checker u_spm_checker (.*);

`default_nettype wire

[sim/spm_checker.sv]
`timescale 1ns / 1ps

module spm_scoreboard (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               byte_valid,
	input  wire logic                               byte_stall,
	input  wire spm_pkg::in_item_t                  byte_item,
	input  wire logic                               res_valid,
	input  wire logic                               res_stall,
	input  wire spm_pkg::out_item_t                 res_item,
	input  wire logic                               cfg_valid,
	input  wire logic                               cfg_ready,
	input  wire logic [spm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [spm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output int                                      fail_count,
	output int                                      pending_count,
	output int                                      checked_count
);

	// shadow copy of the pattern registers
	logic [spm_pkg::LEN_W-1:0]      pat_len = '0;
	logic [spm_pkg::CFG_DATA_W-1:0] pat_lo  = '0;
	logic [spm_pkg::CFG_DATA_W-1:0] pat_hi  = '0;

	// shadow copy of the matching state
	spm_pkg::byte_t held [spm_pkg::PAT_MAX];
	int             held_count = 0;
	int             stars_owed = 0;
	bit             line_open  = 1'b0;

	spm_pkg::out_item_t masked_due [$];

	initial begin
		fail_count    = 0;
		pending_count = 0;
		checked_count = 0;
	end

	function automatic int active_len();
		return (pat_len > spm_pkg::PAT_MAX) ? spm_pkg::PAT_MAX : int'(pat_len);
	endfunction

	function automatic spm_pkg::byte_t pat_at(input int i);
		return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic bit held_is_prefix();
		for (int i = 0; i < held_count; i++)
			if (held[i] != pat_at(i)) return 1'b0;
		return 1'b1;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic push_byte(input spm_pkg::byte_t b, inout int n);
		spm_pkg::out_item_t r;
		r.out_byte = b;
		r.last     = 1'b0;
		masked_due.push_back(r);
		n++;
	endtask

	// give out the oldest held byte, masked while a found match drains
	task automatic release_front(inout int n);
		spm_pkg::byte_t b;
		b = held[0];
		if (stars_owed > 0) begin
			b = spm_pkg::ASTERISK;
			stars_owed--;
		end
		push_byte(b, n);
		for (int i = 1; i < spm_pkg::PAT_MAX; i++)
			held[i-1] = held[i];
		held_count--;
	endtask

	task automatic release_all(inout int n);
		while (held_count > 0)
			release_front(n);
		stars_owed = 0;
	endtask

	task automatic predict_item(input spm_pkg::in_item_t it);
		int n;
		int len;
		n = 0;
		if (it.end_of_input) begin
			if (line_open) begin
				release_all(n);
				push_byte(spm_pkg::NEWLINE, n);
			end
			held_count = 0;
			stars_owed = 0;
			line_open  = 1'b0;
		end else if (it.data_byte == spm_pkg::NEWLINE) begin
			release_all(n);
			push_byte(spm_pkg::NEWLINE, n);
			line_open = 1'b0;
		end else begin
			line_open = 1'b1;
			if (held_count >= spm_pkg::PAT_MAX) release_front(n);
			held[held_count] = it.data_byte;
			held_count++;
			len = active_len();
			while (held_count > 0 && (held_count > len || !held_is_prefix()))
				release_front(n);
			if (len > 0 && held_count == len) begin
				stars_owed = held_count;
				release_all(n);
			end
		end
		if (n > 0) masked_due[masked_due.size()-1].last = 1'b1;
	endtask

	task automatic check_result(input spm_pkg::out_item_t got);
		spm_pkg::out_item_t want;
		checked_count++;
		if (masked_due.size() == 0) begin
			report("unexpected result byte", int'(got.out_byte), -1);
			return;
		end
		want = masked_due.pop_front();
		if (got.out_byte != want.out_byte)
			report("out_byte", int'(got.out_byte), int'(want.out_byte));
		if (got.last != want.last)
			report("last", int'(got.last), int'(want.last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_len    = '0;
			pat_lo     = '0;
			pat_hi     = '0;
			held_count = 0;
			stars_owed = 0;
			line_open  = 1'b0;
			masked_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (spm_pkg::cfg_reg_t'(cfg_index))
					spm_pkg::REG_PATTERN_LEN:  pat_len = cfg_wdata[spm_pkg::LEN_W-1:0];
					spm_pkg::REG_PATTERN_LOW:  pat_lo  = cfg_wdata;
					spm_pkg::REG_PATTERN_HIGH: pat_hi  = cfg_wdata;
					default: ;
				endcase
			end
			if (byte_valid && !byte_stall) predict_item(byte_item);
			if (res_valid && !res_stall) check_result(res_item);
		end
		pending_count = masked_due.size();
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	// Timing budget. The longest quiet stretch is the deliberate receiver
	// hold-off, so the watchdog limit sits well above it.
	localparam int DRAIN_CYCLES   = 24;
	localparam int SQUEEZE_PHASE  = 2;
	localparam int SQUEEZE_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 72;
	localparam int PHASES         = 6;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               byte_valid;
	logic                               byte_stall;
	spm_pkg::in_item_t                  byte_item;
	logic                               res_valid;
	logic                               res_stall;
	spm_pkg::out_item_t                 res_item;
	logic                               cfg_valid;
	logic                               cfg_ready;
	logic [spm_pkg::CFG_IDX_W-1:0]      cfg_index;
	logic [spm_pkg::CFG_DATA_W-1:0]     cfg_wdata;

	int fails;
	int pending;
	int checked;

	// stimulus bookkeeping: the current pattern is kept here only to shape the
	// byte stream so that matches actually happen
	spm_pkg::byte_t pat [spm_pkg::PAT_MAX];
	int    pat_n          = 0;
	int    items_sent     = 0;
	int    settings_used  = 0;
	bit    sender_calm    = 1'b0;
	bit    squeeze_req    = 1'b0;
	bit    squeezed       = 1'b0;
	int    idle_cycles    = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	stream_pattern_masker dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res_item   (res_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	spm_scoreboard u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_valid    (byte_valid),
		.byte_stall    (byte_stall),
		.byte_item     (byte_item),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_item      (res_item),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fails),
		.pending_count (pending),
		.checked_count (checked)
	);

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Offer one byte transaction and hold it until the block takes it. Valid
	// is only lowered when a gap is wanted, so back-to-back transactions keep
	// it high with a single assignment per edge.
	task automatic send_item(input spm_pkg::byte_t d, input logic eoi);
		int gap;
		gap = sender_calm ? 0 : pick_gap();
		if (gap != 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= '{data_byte: d, end_of_input: eoi};
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		items_sent++;
	endtask

	// Drop valid, wait until every predicted result has come out, then give
	// the block time to finish any internal shifting before touching config.
	// The outstanding count is sampled on the falling edge to stay clear of
	// the checker's update on the rising one.
	task automatic settle();
		byte_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Fill the pattern bytes: either fully random, or from a tiny alphabet so
	// that self-overlapping patterns and partial matches are common.
	task automatic fill_pattern(input bit narrow);
		for (int i = 0; i < spm_pkg::PAT_MAX; i++) begin
			if (!narrow) pat[i] = spm_pkg::byte_t'($urandom_range(0, 255));
			else begin
				case ($urandom_range(0, 3))
					0:       pat[i] = 8'h61;
					1:       pat[i] = 8'h62;
					2:       pat[i] = 8'h00;
					default: pat[i] = 8'hFF;
				endcase
			end
		end
	endtask

	// Write all three registers back to back from the pattern bytes. The
	// length word carries random junk above its five live bits.
	task automatic load_pattern(input int len_code);
		logic [spm_pkg::CFG_DATA_W-1:0] lo;
		logic [spm_pkg::CFG_DATA_W-1:0] hi;
		logic [spm_pkg::CFG_DATA_W-1:0] junk;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pat[i];
			hi[8*i +: 8] = pat[i+8];
		end
		junk = {$urandom, $urandom};
		cfg_valid <= 1'b1;
		cfg_index <= spm_pkg::REG_PATTERN_LEN;
		cfg_wdata <= {junk[spm_pkg::CFG_DATA_W-1:spm_pkg::LEN_W],
			spm_pkg::LEN_W'(len_code)};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= spm_pkg::REG_PATTERN_LOW;
		cfg_wdata <= lo;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= spm_pkg::REG_PATTERN_HIGH;
		cfg_wdata <= hi;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		pat_n = (len_code > spm_pkg::PAT_MAX) ? spm_pkg::PAT_MAX : len_code;
		settings_used++;
	endtask

	// Result side: free-flowing stretches, short and long stalls, and once a
	// long hold-off so that the block's buffer fills and it stalls the input
	// while the sender keeps offering. A run is cut short as soon as the
	// hold-off is asked for, so it starts while the sender is busy.
	initial begin : result_sink
		int r;
		int run;
		res_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			r = $urandom_range(0, 99);
			if (!squeezed && squeeze_req) begin
				squeezed = 1'b1;
				res_stall <= 1'b1;
				run = SQUEEZE_CYCLES;
			end else if (r < 15) begin
				res_stall <= 1'b0;
				run = $urandom_range(30, 80);
			end else if (r < 65) begin
				res_stall <= 1'b0;
				run = $urandom_range(1, 3);
			end else if (r < 95) begin
				res_stall <= 1'b1;
				run = $urandom_range(1, 4);
			end else begin
				res_stall <= 1'b1;
				run = $urandom_range(15, 40);
			end
			for (int c = 0; c < run; c++) begin
				@(posedge clk);
				if (!squeezed && squeeze_req) break;
			end
		end
	end

	// Watchdog: count edges at which no transaction moves on any channel.
	always @(posedge clk) begin
		if ((byte_valid && !byte_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d results still due",
				WATCHDOG_LIMIT, pending);
			$display("testbench NOT OK");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : stimulus
		int r;
		int cut;
		int target;
		int len_code;
		byte_valid = 1'b0;
		byte_item  = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;

		// Pull reset low just after time zero so every flop sees the falling
		// edge, hold it, then release it once and never again.
		#0.5 arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset pattern length is zero: every byte passes as it is. Cover both
		// byte extremes, a newline on an empty line, end of input on an empty
		// line (twice, so a fresh stream starts on an empty one too) and end of
		// input that closes a line with an appended newline.
		sender_calm = 1'b1;
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(spm_pkg::NEWLINE, 1'b0);
		send_item(spm_pkg::NEWLINE, 1'b0);
		send_item(8'h5A, 1'b1);
		send_item(8'hA5, 1'b1);
		send_item(8'h41, 1'b0);
		send_item(8'hFF, 1'b1);
		settle();

		// Three-byte pattern with a NUL in it: "a", NUL, "b".
		sender_calm = 1'b0;
		fill_pattern(1'b0);
		pat[0] = 8'h61;
		pat[1] = 8'h00;
		pat[2] = 8'h62;
		load_pattern(3);
		// clean hit
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h62, 1'b0);
		// false start then hit: the first "a" drops out unmasked
		send_item(8'h61, 1'b0);
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h62, 1'b0);
		// partial match cut by a newline: held bytes flush unmasked
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(spm_pkg::NEWLINE, 1'b0);
		// partial match cut by end of input
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b1);

		// Change the pattern mid-line with a partial match held: the held
		// bytes are re-examined against "xy" on the next byte and drop out.
		send_item(8'h61, 1'b0);
		send_item(8'h00, 1'b0);
		settle();
		fill_pattern(1'b0);
		pat[0] = 8'h78;
		pat[1] = 8'h79;
		load_pattern(2);
		send_item(8'h78, 1'b0);
		send_item(8'h79, 1'b0);
		send_item(8'h00, 1'b1);

		// Random phases. Lengths walk the extremes (full width, saturated,
		// single byte, disabled) and then a couple of mid sizes. Each phase
		// may end mid-line, so the next write also lands on held bytes. One
		// phase opens with the long receiver hold-off.
		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph)
				0:       len_code = spm_pkg::PAT_MAX;
				1:       len_code = 31;
				2:       len_code = 1;
				3:       len_code = 0;
				default: len_code = $urandom_range(2, spm_pkg::PAT_MAX - 1);
			endcase
			fill_pattern(ph[0]);
			load_pattern(len_code);
			if (ph == SQUEEZE_PHASE) squeeze_req = 1'b1;
			sender_calm = ($urandom_range(0, 3) == 0);
			target = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target) begin
				r = $urandom_range(0, 99);
				if (pat_n > 0 && r < 25) begin
					// whole pattern: a hit unless earlier held bytes shift it
					for (int k = 0; k < pat_n; k++)
						send_item(pat[k], 1'b0);
				end else if (pat_n > 1 && r < 40) begin
					// prefix then a random byte: usually a broken match
					cut = $urandom_range(1, pat_n - 1);
					for (int k = 0; k < cut; k++)
						send_item(pat[k], 1'b0);
					send_item(spm_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
				end else if (pat_n > 0 && r < 65)
					send_item(pat[$urandom_range(0, pat_n - 1)], 1'b0);
				else if (r < 88)
					send_item(spm_pkg::byte_t'($urandom_range(0, 255)), 1'b0);
				else if (r < 96)
					send_item(spm_pkg::NEWLINE, 1'b0);
				else
					send_item(spm_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
			end
		end

		// Close the stream so the last held bytes come out, then drain.
		send_item(spm_pkg::byte_t'($urandom_range(0, 255)), 1'b1);
		settle();

		$display("run covered %0d byte transactions under %0d pattern settings, %0d results checked",
			items_sent, settings_used, checked);
		if (fails == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule

[filelist.f]
rtl/spm_pkg.sv
rtl/spm_cell.sv
rtl/spm_out_fifo.sv
rtl/stream_pattern_masker.sv
rtl/spm_checker.sv
sim/spm_checker.sv
sim/testbench.sv
